@@ sv/lpe_pkg.sv @@
// shared constants, codes and types for the positional list engine
package lpe_pkg;

   localparam int DEPTH = 16;
   localparam int POS_W = 5;
   localparam int VALUE_W = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic signed [VALUE_W-1:0] READ_MISS = '1;

   typedef enum logic [1:0] {
      FUNC_FETCH  = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_INSERT = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                      ins_en;
      logic                      del_en;
      logic [CMP_W-1:0]          pos;
      logic signed [VALUE_W-1:0] new_value;
   } cell_cmd_type;

endpackage

@@ sv/lpe_if.sv @@
// request and response channel interfaces
interface lpe_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           func;
   logic [4:0]           position;
   logic signed [31:0]   new_value;

   modport source (output valid, func, position, new_value, input ready);
   modport sink (input valid, func, position, new_value, output ready);
   modport monitor (input valid, ready, func, position, new_value);
endinterface

interface lpe_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [31:0]   read_value;
   logic [1:0]           status;

   modport source (output valid, read_value, status, input ready);
   modport sink (input valid, read_value, status, output ready);
   modport monitor (input valid, ready, read_value, status);
endinterface

@@ sv/positional_list_engine_top.sv @@
// positional list engine: top level with decode, count and response register
// An ordered list of up to DEPTH signed 32-bit entries kept in a row of cells.
// Each request beat fetches, deletes or inserts at a zero-based position and
// presents exactly one response in the cycle after it is accepted. Every
// operation takes effect on acceptance because each cell compares its own
// index with the position and takes its neighbour's entry in the same clock,
// so one request is taken per cycle as long as the response side keeps up;
// the single response register lets a new request in while the previous
// response is being taken. Fetch and delete at or beyond the count, insert
// beyond it and any unused func report out of range; insert into a full list reports full.
module positional_list_engine_top (
   input  logic              clock,
   input  logic              reset,
   lpe_req_if.sink           req_bus,
   lpe_rsp_if.source         rsp_bus
);

   logic [lpe_pkg::CNT_W-1:0]             count_ff;
   logic [lpe_pkg::CNT_W-1:0]             count_in;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   logic signed [lpe_pkg::VALUE_W-1:0]    rsp_read_value_ff;
   logic signed [lpe_pkg::VALUE_W-1:0]    rsp_read_value_in;
   lpe_pkg::status_type                   rsp_status_ff;
   lpe_pkg::status_type                   rsp_status_in;

   logic                                  accept;
   logic [lpe_pkg::CMP_W-1:0]             pos_ext;
   logic [lpe_pkg::CMP_W-1:0]             cnt_ext;
   lpe_pkg::cell_cmd_type                 cmd;
   logic signed [lpe_pkg::VALUE_W-1:0]    fetched;

   logic signed [lpe_pkg::VALUE_W-1:0]    chain [lpe_pkg::DEPTH];
   logic signed [lpe_pkg::VALUE_W-1:0]    taps [lpe_pkg::DEPTH];

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept = req_bus.valid && req_bus.ready;
   assign pos_ext = lpe_pkg::CMP_W'(req_bus.position);
   assign cnt_ext = lpe_pkg::CMP_W'(count_ff);

   // the cell row
   for (genvar g = 0; g < lpe_pkg::DEPTH; g++) begin : g_cell
      logic signed [lpe_pkg::VALUE_W-1:0] prev_v;
      logic signed [lpe_pkg::VALUE_W-1:0] next_v;
      if (g == 0) begin : g_first
         assign prev_v = '0;
      end else begin : g_prev
         assign prev_v = chain[g-1];
      end
      if (g == lpe_pkg::DEPTH - 1) begin : g_last
         assign next_v = chain[g];
      end else begin : g_next
         assign next_v = chain[g+1];
      end
      lpe_cell u_cell (
         .clock      (clock),
         .cell_index (lpe_pkg::CNT_W'(g)),
         .cmd        (cmd),
         .prev_value (prev_v),
         .next_value (next_v),
         .value      (chain[g]),
         .tap_value  (taps[g])
      );
   end

   always_comb begin
      fetched = '0;
      for (int i = 0; i < lpe_pkg::DEPTH; i++) begin
         fetched = fetched | taps[i];
      end
   end

   always_comb begin
      cmd.ins_en = 1'b0;
      cmd.del_en = 1'b0;
      cmd.pos = pos_ext;
      cmd.new_value = req_bus.new_value;
      count_in = count_ff;
      rsp_read_value_in = '0;
      rsp_status_in = lpe_pkg::ST_OK;
      unique case (req_bus.func)
         lpe_pkg::FUNC_FETCH: begin
            if (pos_ext < cnt_ext) begin
               rsp_read_value_in = fetched;
            end else begin
               rsp_read_value_in = lpe_pkg::READ_MISS;
               rsp_status_in = lpe_pkg::ST_RANGE;
            end
         end
         lpe_pkg::FUNC_DELETE: begin
            if (pos_ext < cnt_ext) begin
               cmd.del_en = accept;
               count_in = count_ff - 1'b1;
            end else begin
               rsp_status_in = lpe_pkg::ST_RANGE;
            end
         end
         lpe_pkg::FUNC_INSERT: begin
            if (pos_ext > cnt_ext) begin
               rsp_status_in = lpe_pkg::ST_RANGE;
            end else if (count_ff == lpe_pkg::CNT_W'(lpe_pkg::DEPTH)) begin
               rsp_status_in = lpe_pkg::ST_FULL;
            end else begin
               cmd.ins_en = accept;
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
            rsp_status_in = lpe_pkg::ST_RANGE;
         end
      endcase
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.read_value = rsp_read_value_ff;
   assign rsp_bus.status = rsp_status_ff;

endmodule

@@ sv/lpe_cell.sv @@
// one list cell: holds one entry and shifts with its neighbours
module lpe_cell (
   input  logic                                  clock,
   input  logic [lpe_pkg::CNT_W-1:0]             cell_index,
   input  lpe_pkg::cell_cmd_type                 cmd,
   input  logic signed [lpe_pkg::VALUE_W-1:0]    prev_value,
   input  logic signed [lpe_pkg::VALUE_W-1:0]    next_value,
   output logic signed [lpe_pkg::VALUE_W-1:0]    value,
   output logic signed [lpe_pkg::VALUE_W-1:0]    tap_value
);

   logic [lpe_pkg::CMP_W-1:0]             idx_ext;
   logic signed [lpe_pkg::VALUE_W-1:0]    value_ff;
   logic signed [lpe_pkg::VALUE_W-1:0]    value_in;

   assign idx_ext = lpe_pkg::CMP_W'(cell_index);

   always_comb begin
      value_in = value_ff;
      if (cmd.ins_en) begin
         if (idx_ext > cmd.pos) begin
            value_in = prev_value;
         end else if (idx_ext == cmd.pos) begin
            value_in = cmd.new_value;
         end
      end else if (cmd.del_en) begin
         if (idx_ext >= cmd.pos) begin
            value_in = next_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   // only the addressed cell drives the read bus
   assign tap_value = (idx_ext == cmd.pos) ? value_ff : '0;

endmodule

@@ sv/lpe_checker.sv @@
// port-level checks for the positional list engine, bound to the top level
module lpe_checker (
   input  logic        clock,
   input  logic        reset,
   lpe_req_if.sink     req_bus,
   lpe_rsp_if.source   rsp_bus
);

   logic req_beat;
   logic rsp_stall;

   assign req_beat = req_bus.valid && req_bus.ready;
   assign rsp_stall = rsp_bus.valid && !rsp_bus.ready;

   // every request beat gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_bus.valid)
      else $error("no response after request beat");

   // a fresh response needs a request beat just before it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !$past(rsp_stall) && !$past(reset)) |-> $past(req_beat))
      else $error("response without request beat");

   // full status carries a zero value
   a_status_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == lpe_pkg::ST_FULL) |->
         (rsp_bus.read_value == '0))
      else $error("full status with nonzero value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_stall |=> (rsp_bus.valid && $stable(rsp_bus.read_value)
                     && $stable(rsp_bus.status)))
      else $error("stalled response changed");

   // request is refused only while a response is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_stall)
      else $error("request refused without stalled response");

endmodule

bind positional_list_engine_top lpe_checker u_lpe_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

@@ bench/tb_list_checker.sv @@
// checker for the positional list engine: request/response monitor, list predictor, compare
`timescale 1ns / 100ps

module list_checker (
   input  logic         clock,
   input  logic         reset,
   lpe_req_if.monitor   req_mon,
   lpe_rsp_if.monitor   rsp_mon,
   output int           fail_count,
   output int           outstanding,
   output int           peak_len,
   output int           full_refusals
);

   typedef struct {
      logic signed [lpe_pkg::VALUE_W-1:0] read_value;
      lpe_pkg::status_type                status;
   } list_outcome_type;

   logic signed [lpe_pkg::VALUE_W-1:0] entry_vals [lpe_pkg::DEPTH];
   int                                 entry_total;
   list_outcome_type                   pending_outcomes [$];
   list_outcome_type                   oldest;
   int                                 rsp_seen;

   // applies one operation to the shadow list and returns the response it gives
   function automatic list_outcome_type apply_list_op(logic [1:0] f,
                                                      logic [lpe_pkg::POS_W-1:0] p,
                                                      logic signed [lpe_pkg::VALUE_W-1:0] v);
      list_outcome_type res;
      int               at;
      res.read_value = '0;
      res.status     = lpe_pkg::ST_OK;
      at             = int'(p);
      case (f)
         lpe_pkg::FUNC_FETCH: begin
            if (at < entry_total) begin
               res.read_value = entry_vals[at];
            end else begin
               res.read_value = lpe_pkg::READ_MISS;
               res.status     = lpe_pkg::ST_RANGE;
            end
         end
         lpe_pkg::FUNC_DELETE: begin
            if (at < entry_total) begin
               for (int i = at; i + 1 < entry_total; i++) entry_vals[i] = entry_vals[i+1];
               entry_total--;
            end else begin
               res.status = lpe_pkg::ST_RANGE;
            end
         end
         lpe_pkg::FUNC_INSERT: begin
            // range check comes before the full check
            if (at > entry_total) begin
               res.status = lpe_pkg::ST_RANGE;
            end else if (entry_total >= lpe_pkg::DEPTH) begin
               res.status = lpe_pkg::ST_FULL;
               full_refusals++;
            end else begin
               for (int i = entry_total; i > at; i--) entry_vals[i] = entry_vals[i-1];
               entry_vals[at] = v;
               entry_total++;
               if (entry_total > peak_len) peak_len = entry_total;
            end
         end
         default: begin
            res.status = lpe_pkg::ST_RANGE;
         end
      endcase
      return res;
   endfunction

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      $display("response %0d: %s expected %08h, got %08h", rsp_seen, what, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entry_total   = 0;
         pending_outcomes.delete();
         fail_count    = 0;
         peak_len      = 0;
         full_refusals = 0;
         rsp_seen      = 0;
         outstanding  <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            pending_outcomes.push_back(apply_list_op(req_mon.func, req_mon.position,
                                                     req_mon.new_value));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_outcomes.size() == 0) begin
               report("unexpected beat, read_value", 32'hx, rsp_mon.read_value);
            end else begin
               oldest = pending_outcomes.pop_front();
               if (rsp_mon.read_value !== oldest.read_value)
                  report("read_value", oldest.read_value, rsp_mon.read_value);
               if (rsp_mon.status !== oldest.status)
                  report("status", 32'(oldest.status), 32'(rsp_mon.status));
            end
            rsp_seen++;
         end
         outstanding <= pending_outcomes.size();
      end
   end

endmodule

@@ bench/tb_top.sv @@
// top of the positional list engine bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 550;

   logic clock;
   logic reset;
   logic stall_on;

   int fail_count;
   int outstanding;
   int peak_len;
   int full_refusals;
   int sent_cnt [4];
   int list_len_est;

   logic [1:0]                         pick_func;
   logic [lpe_pkg::POS_W-1:0]          pick_pos;
   logic signed [lpe_pkg::VALUE_W-1:0] pick_val;

   lpe_req_if req_bus ();
   lpe_rsp_if rsp_bus ();

   positional_list_engine_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   list_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .peak_len      (peak_len),
      .full_refusals (full_refusals)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #1_600_000;
      $display("timed out with %0d responses outstanding", outstanding);
      $display("Mismatches found");
      $finish;
   end

   // response side back-pressure
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= stall_on ? ($urandom_range(0, 99) >= 31) : 1'b1;
      end
   end

   // one request beat, with random gaps ahead of it; returns on the accepting edge
   task automatic send_req(input logic [1:0] f, input logic [lpe_pkg::POS_W-1:0] p,
                           input logic signed [lpe_pkg::VALUE_W-1:0] v);
      while (stall_on && $urandom_range(0, 99) < 31) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= f;
      req_bus.position  <= p;
      req_bus.new_value <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_cnt[f]++;
      // rough length tracking, only to steer positions
      if (f == lpe_pkg::FUNC_INSERT && int'(p) <= list_len_est && list_len_est < lpe_pkg::DEPTH)
         list_len_est++;
      else if (f == lpe_pkg::FUNC_DELETE && int'(p) < list_len_est)
         list_len_est--;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // mostly well-formed positions, grow and shrink phases, some noise
   task automatic pick_random(input int k);
      int  roll;
      bit  grow;
      roll = $urandom_range(0, 99);
      grow = ((k / 48) % 2) == 0;
      if ($urandom_range(0, 99) < 15) begin
         pick_func = 2'($urandom_range(0, 3));
         pick_pos  = lpe_pkg::POS_W'($urandom_range(0, 31));
      end else begin
         if (roll < (grow ? 55 : 20))
            pick_func = lpe_pkg::FUNC_INSERT;
         else if (roll < (grow ? 80 : 45))
            pick_func = lpe_pkg::FUNC_FETCH;
         else
            pick_func = lpe_pkg::FUNC_DELETE;
         if (pick_func == lpe_pkg::FUNC_INSERT)
            pick_pos = lpe_pkg::POS_W'($urandom_range(0, list_len_est));
         else if (list_len_est == 0)
            pick_pos = '0;
         else
            pick_pos = lpe_pkg::POS_W'($urandom_range(0, list_len_est - 1));
      end
      case ($urandom_range(0, 39))
         0: pick_val = 32'sh7fffffff;
         1: pick_val = 32'sh80000000;
         2: pick_val = '0;
         3: pick_val = -1;
         default: pick_val = $urandom;
      endcase
   endtask

   initial begin
      int waited;
      reset             = 1'b1;
      stall_on          = 1'b1;
      list_len_est      = 0;
      req_bus.valid     = 1'b0;
      req_bus.func      = lpe_pkg::FUNC_FETCH;
      req_bus.position  = '0;
      req_bus.new_value = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list: misses, refused delete, insert past the end
      send_req(lpe_pkg::FUNC_FETCH, 0, 0);
      send_req(lpe_pkg::FUNC_DELETE, 0, 0);
      send_req(lpe_pkg::FUNC_INSERT, 1, 32'sh5);
      // first insert into empty list, append, head and middle inserts, one insert past the end
      send_req(lpe_pkg::FUNC_INSERT, 0, 32'sh7fffffff);
      send_req(lpe_pkg::FUNC_INSERT, 1, 32'sh80000000);
      send_req(lpe_pkg::FUNC_INSERT, 0, -1);
      send_req(lpe_pkg::FUNC_INSERT, 1, 0);
      send_req(lpe_pkg::FUNC_INSERT, 5, 32'sh9);
      for (int i = 0; i < 4; i++) send_req(lpe_pkg::FUNC_FETCH, lpe_pkg::POS_W'(i), 0);
      send_req(lpe_pkg::FUNC_FETCH, 4, 0);
      send_req(lpe_pkg::FUNC_FETCH, 31, 0);
      send_req(lpe_pkg::FUNC_DELETE, 31, 0);
      send_req(lpe_pkg::FUNC_INSERT, 31, 32'sh12345678);
      send_req(FUNC_UNUSED, 0, 32'sh0badcafe);
      // middle, head, then tail delete
      send_req(lpe_pkg::FUNC_DELETE, 1, 0);
      send_req(lpe_pkg::FUNC_DELETE, 0, 0);
      send_req(lpe_pkg::FUNC_DELETE, 1, 0);
      send_req(lpe_pkg::FUNC_FETCH, 0, 0);
      wait_drained();

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         stall_on = !(k >= 200 && k < 330);
         if (k == 400) wait_drained();
         pick_random(k);
         send_req(pick_func, pick_pos, pick_val);
      end

      req_bus.valid <= 1'b0;
      stall_on = 1'b1;
      waited   = 0;
      @(posedge clock);
      while (outstanding != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);

      $display("covered %0d fetch, %0d delete, %0d insert and %0d unused-func requests",
               sent_cnt[lpe_pkg::FUNC_FETCH], sent_cnt[lpe_pkg::FUNC_DELETE],
               sent_cnt[lpe_pkg::FUNC_INSERT], sent_cnt[FUNC_UNUSED]);
      $display("list reached %0d of %0d entries, %0d inserts refused as full",
               peak_len, lpe_pkg::DEPTH, full_refusals);
      if (outstanding != 0)
         $display("%0d responses never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/lpe_pkg.sv
sv/lpe_if.sv
sv/lpe_cell.sv
sv/positional_list_engine_top.sv
sv/lpe_checker.sv
bench/tb_list_checker.sv
bench/tb_top.sv
